// File: src/skht_pkg.sv
// Shared types and constants of the string-key hash table.
`timescale 1ns / 1ps
package skht_pkg;

    localparam int KEY_BYTES     = 8;
    localparam int KEY_BITS      = 8 * KEY_BYTES;
    localparam int VALUE_BITS    = 32;
    localparam int SLOT_COUNT_W  = 9;
    localparam int SLOT_OUT_W    = 8;
    localparam int HASH_W        = 64;
    localparam int BYTE_CNT_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int MOD_STEP      = 8;
    localparam int MOD_CYCLES    = HASH_W / MOD_STEP;
    localparam int MOD_CNT_W     = $clog2(MOD_CYCLES);

    localparam logic [HASH_W-1:0]       HASH_SEED        = 64'd2;
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 9'd256;

    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        H_IDLE,
        H_HASH,
        H_MOD
    } t_hstate;

endpackage

// File: src/skht_ram.sv
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module skht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/skht_hash.sv
// Key normalization, byte-serial hash and multi-cycle modulo to the home slot.
`timescale 1ns / 1ps
module skht_hash #(
    parameter int ADDR_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [skht_pkg::KEY_BITS-1:0] i_key,
    input  logic [ADDR_W:0]              i_n,
    output logic                         o_done,
    output logic [skht_pkg::KEY_BITS-1:0] o_key,
    output logic [ADDR_W-1:0]            o_home
);

    skht_pkg::t_hstate r_state;
    skht_pkg::t_hstate n_state;

    logic [skht_pkg::KEY_BITS-1:0]   r_key;
    logic [skht_pkg::KEY_BITS-1:0]   r_shift;
    logic [skht_pkg::HASH_W-1:0]     r_hash;
    logic [skht_pkg::BYTE_CNT_W-1:0] r_cnt;
    logic [skht_pkg::MOD_CNT_W-1:0]  r_mcnt;
    logic [ADDR_W-1:0]               r_rem;

    logic                            w_live;
    logic [skht_pkg::KEY_BITS-1:0]   w_norm;
    logic [7:0]                      w_byte;
    logic [10:0]                     w_byte5;
    logic [skht_pkg::HASH_W-1:0]     w_h3;
    logic [skht_pkg::HASH_W-1:0]     w_hnext;
    logic                            w_hash_end;
    logic                            w_mod_end;
    logic [ADDR_W:0]                 w_t;
    logic [ADDR_W-1:0]               w_rem;

    // Drop every byte from the first zero byte on.
    always_comb begin
        w_live = 1'b1;
        w_norm = '0;
        for (int b = 0; b < skht_pkg::KEY_BYTES; b++) begin
            if (i_key[8*b +: 8] == 8'd0) begin
                w_live = 1'b0;
            end
            if (w_live) begin
                w_norm[8*b +: 8] = i_key[8*b +: 8];
            end
        end
    end

    // hash*3 xor byte*5, written as shift-adds
    assign w_byte     = r_shift[7:0];
    assign w_byte5    = {1'b0, w_byte, 2'b00} + {3'b000, w_byte};
    assign w_h3       = r_hash + {r_hash[skht_pkg::HASH_W-2:0], 1'b0};
    assign w_hnext    = w_h3 ^ {{(skht_pkg::HASH_W-11){1'b0}}, w_byte5};
    assign w_hash_end = (w_byte == 8'd0)
                     || (r_cnt == skht_pkg::BYTE_CNT_W'(skht_pkg::KEY_BYTES - 1));
    assign w_mod_end  = (r_mcnt == skht_pkg::MOD_CNT_W'(skht_pkg::MOD_CYCLES - 1));

    // Restoring remainder, one byte of the hash per cycle, MSB first.
    always_comb begin
        w_rem = r_rem;
        w_t   = '0;
        for (int k = 0; k < skht_pkg::MOD_STEP; k++) begin
            w_t = {w_rem, r_hash[skht_pkg::HASH_W-1-k]};
            if (w_t >= i_n) begin
                w_t = w_t - i_n;
            end
            w_rem = w_t[ADDR_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            skht_pkg::H_IDLE: begin
                if (i_start) begin
                    n_state = skht_pkg::H_HASH;
                end
            end
            skht_pkg::H_HASH: begin
                if (w_hash_end) begin
                    n_state = skht_pkg::H_MOD;
                end
            end
            skht_pkg::H_MOD: begin
                if (w_mod_end) begin
                    n_state = skht_pkg::H_IDLE;
                end
            end
            default: begin
                n_state = skht_pkg::H_IDLE;
            end
        endcase
    end

    always_comb begin
        o_done = (r_state == skht_pkg::H_MOD) && w_mod_end;
        o_key  = r_key;
        o_home = w_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skht_pkg::H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            skht_pkg::H_IDLE: begin
                if (i_start) begin
                    r_key   <= w_norm;
                    r_shift <= w_norm;
                    r_hash  <= skht_pkg::HASH_SEED;
                    r_cnt   <= '0;
                    r_mcnt  <= '0;
                    r_rem   <= '0;
                end
            end
            skht_pkg::H_HASH: begin
                if (w_byte != 8'd0) begin
                    r_hash <= w_hnext;
                end
                r_shift <= r_shift >> 8;
                r_cnt   <= r_cnt + 1'b1;
            end
            skht_pkg::H_MOD: begin
                r_rem  <= w_rem;
                r_hash <= r_hash << skht_pkg::MOD_STEP;
                r_mcnt <= r_mcnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/string_key_hash_table.sv
// Top level: open-addressing string-key hash table; probe i moves on i*i slots from the last.
//
//   channel | valid       | ready        | payload
//   --------+-------------+--------------+-------------------------------
//   in      | i_in_valid  | o_in_ready   | i_kind, i_key, i_value
//   out     | o_out_valid | i_out_ready  | o_status, o_slot, o_data
//   cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_data (slot_count)
//
// After reset the block sweeps both memories to zero, one entry a cycle,
// over all TABLE_DEPTH entries, and takes no request until the sweep is done.
// A request is taken in the idle state, its key bytes up to the first zero byte
// are hashed one a cycle, the hash is reduced modulo the slot count, each probe
// reads memory, then compares and writes back; then the result is loaded.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
`timescale 1ns / 1ps
module string_key_hash_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [skht_pkg::KEY_BITS-1:0]     i_key,
    input  logic [skht_pkg::VALUE_BITS-1:0]   i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_status,
    output logic [skht_pkg::SLOT_OUT_W-1:0]   o_slot,
    output logic [skht_pkg::VALUE_BITS-1:0]   o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [skht_pkg::SLOT_COUNT_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int NW     = ADDR_W + 1;
    localparam int SW     = (NW > skht_pkg::SLOT_COUNT_W) ? NW : skht_pkg::SLOT_COUNT_W;

    skht_pkg::t_state  r_state;
    skht_pkg::t_state  n_state;

    logic [skht_pkg::SLOT_COUNT_W-1:0] r_slot_count;
    logic [ADDR_W-1:0]                 r_clr;
    logic                              r_kind;
    logic [skht_pkg::VALUE_BITS-1:0]   r_value;
    logic [skht_pkg::KEY_BITS-1:0]     r_key;
    logic [ADDR_W-1:0]                 r_idx;
    logic [ADDR_W-1:0]                 r_q;
    logic [ADDR_W-1:0]                 r_d;
    logic [NW-1:0]                     r_probes;
    skht_pkg::t_status                 r_res_status;
    logic [skht_pkg::VALUE_BITS-1:0]   r_res_data;
    logic                              r_out_valid;
    logic [2:0]                        r_out_status;
    logic [skht_pkg::SLOT_OUT_W-1:0]   r_out_slot;
    logic [skht_pkg::VALUE_BITS-1:0]   r_out_data;

    logic [SW-1:0]                     w_sc_ext;
    logic [SW-1:0]                     w_depth;
    logic [SW-1:0]                     w_nsel;
    logic [NW-1:0]                     w_n;
    logic                              w_hstart;
    logic                              w_hdone;
    logic [skht_pkg::KEY_BITS-1:0]     w_hkey;
    logic [ADDR_W-1:0]                 w_hhome;
    logic [skht_pkg::KEY_BITS-1:0]     w_rkey;
    logic [skht_pkg::VALUE_BITS-1:0]   w_rval;
    logic                              w_we;
    logic [ADDR_W-1:0]                 w_waddr;
    logic [skht_pkg::KEY_BITS-1:0]     w_wkey;
    logic [skht_pkg::VALUE_BITS-1:0]   w_wval;
    logic                              w_empty;
    logic                              w_match;
    logic                              w_hit;
    logic                              w_last;
    logic                              w_put;
    logic                              w_emit;
    skht_pkg::t_status                 w_stat;
    logic [NW-1:0]                     w_qsum;
    logic [ADDR_W-1:0]                 w_qn;
    logic [NW-1:0]                     w_isum;
    logic [ADDR_W-1:0]                 w_idx_next;
    logic [NW-1:0]                     w_dsum;
    logic [ADDR_W-1:0]                 w_dn;
    logic [ADDR_W-1:0]                 w_d_init;
    logic [ADDR_W+skht_pkg::SLOT_OUT_W-1:0] w_slot_ext;

    // Active slot count: zero acts as one, clamp to the table depth.
    assign w_sc_ext = SW'(r_slot_count);
    assign w_depth  = SW'(TABLE_DEPTH);
    assign w_nsel   = (w_sc_ext == '0) ? SW'(1)
                    : ((w_sc_ext > w_depth) ? w_depth : w_sc_ext);
    assign w_n      = w_nsel[NW-1:0];

    skht_hash #(
        .ADDR_W (ADDR_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_key   (i_key),
        .i_n     (w_n),
        .o_done  (w_hdone),
        .o_key   (w_hkey),
        .o_home  (w_hhome)
    );

    skht_ram #(
        .WIDTH (skht_pkg::KEY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wkey),
        .i_raddr (r_idx),
        .o_rdata (w_rkey)
    );

    skht_ram #(
        .WIDTH (skht_pkg::VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wval),
        .i_raddr (r_idx),
        .o_rdata (w_rval)
    );

    // Probe step: q tracks i*i mod n, d tracks 2i+1 mod n.
    assign w_qsum     = {1'b0, r_q} + {1'b0, r_d};
    assign w_qn       = (w_qsum >= w_n) ? ADDR_W'(w_qsum - w_n) : w_qsum[ADDR_W-1:0];
    assign w_isum     = {1'b0, r_idx} + {1'b0, w_qn};
    assign w_idx_next = (w_isum >= w_n) ? ADDR_W'(w_isum - w_n) : w_isum[ADDR_W-1:0];
    assign w_dsum     = {1'b0, r_d} + NW'(2);
    assign w_dn       = (w_dsum >= w_n) ? ADDR_W'(w_dsum - w_n) : w_dsum[ADDR_W-1:0];
    assign w_d_init   = (w_n == NW'(1)) ? '0 : ADDR_W'(1);

    assign w_empty = (w_rkey == '0);
    assign w_match = (w_rkey == r_key);
    assign w_hit   = w_empty || w_match;
    assign w_last  = ((r_probes + NW'(1)) == w_n);
    assign w_put   = (r_kind == skht_pkg::KIND_PUT);
    assign w_emit  = (r_state == skht_pkg::S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        if (w_empty) begin
            w_stat = w_put ? skht_pkg::STAT_INSERTED : skht_pkg::STAT_NOT_FOUND;
        end else if (w_match) begin
            w_stat = w_put ? skht_pkg::STAT_UPDATED : skht_pkg::STAT_FOUND;
        end else begin
            w_stat = skht_pkg::STAT_FULL;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            skht_pkg::S_CLEAR: begin
                if (r_clr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_state = skht_pkg::S_IDLE;
                end
            end
            skht_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = skht_pkg::S_HASH;
                end
            end
            skht_pkg::S_HASH: begin
                if (w_hdone) begin
                    n_state = skht_pkg::S_READ;
                end
            end
            skht_pkg::S_READ: begin
                n_state = skht_pkg::S_CHECK;
            end
            skht_pkg::S_CHECK: begin
                n_state = (w_hit || w_last) ? skht_pkg::S_EMIT : skht_pkg::S_READ;
            end
            skht_pkg::S_EMIT: begin
                if (w_emit) begin
                    n_state = skht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skht_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == skht_pkg::S_IDLE);
        w_hstart   = (r_state == skht_pkg::S_IDLE) && i_in_valid;
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wkey     = r_key;
        w_wval     = r_value;
        case (r_state)
            skht_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wkey  = '0;
                w_wval  = '0;
            end
            skht_pkg::S_CHECK: begin
                // a put that ends on an empty or matching slot writes back
                w_we = w_hit && w_put;
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;
    assign o_data      = r_out_data;
    assign w_slot_ext  = {{skht_pkg::SLOT_OUT_W{1'b0}}, r_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= skht_pkg::S_CLEAR;
            r_clr        <= '0;
            r_slot_count <= skht_pkg::SLOT_COUNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == skht_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                r_slot_count <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            skht_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_kind  <= i_kind;
                    r_value <= i_value;
                end
            end
            skht_pkg::S_HASH: begin
                if (w_hdone) begin
                    r_key    <= w_hkey;
                    r_idx    <= w_hhome;
                    r_q      <= '0;
                    r_d      <= w_d_init;
                    r_probes <= '0;
                end
            end
            skht_pkg::S_CHECK: begin
                if (w_hit || w_last) begin
                    r_res_status <= w_stat;
                    r_res_data   <= (w_hit && w_put) ? r_value : w_rval;
                end else begin
                    r_idx    <= w_idx_next;
                    r_q      <= w_qn;
                    r_d      <= w_dn;
                    r_probes <= r_probes + 1'b1;
                end
            end
            skht_pkg::S_EMIT: begin
                if (w_emit) begin
                    r_out_status <= r_res_status;
                    r_out_slot   <= w_slot_ext[skht_pkg::SLOT_OUT_W-1:0];
                    r_out_data   <= r_res_data;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/skht_chk.sv
// Port-level checker for the hash table, bound to the top level.
`timescale 1ns / 1ps
module skht_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_kind,
    input logic [skht_pkg::KEY_BITS-1:0]     i_key,
    input logic [skht_pkg::VALUE_BITS-1:0]   i_value,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [2:0]                        o_status,
    input logic [skht_pkg::SLOT_OUT_W-1:0]   o_slot,
    input logic [skht_pkg::VALUE_BITS-1:0]   o_data,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [skht_pkg::SLOT_COUNT_W-1:0] i_cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_status) && $stable(o_slot) && $stable(o_data))
        else $error("stalled result changed");

    // one request in work at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= skht_pkg::STAT_FULL))
        else $error("undefined status code");

endmodule

bind string_key_hash_table skht_chk u_skht_chk (.*);
